@@ rtl/lrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int CH_BITS         = 3;
    localparam int COEF_BITS       = 32;
    localparam int UCOEF_BITS      = 31;
    localparam int CFG_IDX_BITS    = 3;
    localparam int QUO_BITS        = 62;

    localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_COEFF  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_ONE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_TWO = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_SCALE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_GAIN  = 3'd4;

    localparam logic [30:0] CLIP_SCALE_RST  = 31'h0800_0000;
    localparam logic [30:0] OUTPUT_GAIN_RST = 31'h1000_0000;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture beat
        logic mul_a;     // read channel state, a1*x
        logic mul_b1;    // b1*y1
        logic mul_b2;    // b2*y2, then sum
        logic sum;       // saturate y, write state, start divider
        logic div_step;  // one quotient bit
        logic fin;       // diff*gain
        logic outp;      // saturate, load output register
    } lrs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic out_full;
    } lrs_sts_t;

endpackage

@@ rtl/lrs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_datapath
// Resonator, restoring divider for the soft clipper, output stage.
// ----------------------------------------------------------------------------
module lrs_datapath #(
    parameter int CHANNELS    = lrs_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = lrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lrs_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
    input  logic [lrs_pkg::COEF_BITS-1:0]       cfg_data,
    input  logic [lrs_pkg::CH_BITS-1:0]         in_channel,
    input  logic signed [SAMPLE_BITS-1:0]       in_sample,
    input  lrs_pkg::lrs_cmd_t                   cmd,
    output lrs_pkg::lrs_sts_t                   sts,
    input  logic                                out_take,
    output logic [lrs_pkg::CH_BITS-1:0]         out_channel,
    output logic signed [SAMPLE_BITS-1:0]       out_sample
);
    localparam int CW = lrs_pkg::CH_BITS;
    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QB = lrs_pkg::QUO_BITS;
    localparam int DC = $clog2(QB + 1);
    // two feedback terms can each reach 2^34, so the sum needs headroom
    localparam int AW = 38;

    logic signed [31:0] a1_reg, b1_reg, b2_reg;
    logic [30:0]        c_reg, g_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a1_reg <= '0;
            b1_reg <= '0;
            b2_reg <= '0;
            c_reg  <= lrs_pkg::CLIP_SCALE_RST;
            g_reg  <= lrs_pkg::OUTPUT_GAIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                lrs_pkg::REG_INPUT_COEFF:  a1_reg <= cfg_data;
                lrs_pkg::REG_FEEDBACK_ONE: b1_reg <= cfg_data;
                lrs_pkg::REG_FEEDBACK_TWO: b2_reg <= cfg_data;
                lrs_pkg::REG_CLIP_SCALE:   c_reg  <= cfg_data[30:0];
                lrs_pkg::REG_OUTPUT_GAIN:  g_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // per-channel state, valid bits give the zero reset
    logic signed [31:0] y1_mem [CHANNELS];
    logic signed [31:0] y2_mem [CHANNELS];
    logic signed [31:0] yc_mem [CHANNELS];
    logic [CHANNELS-1:0] vld_reg;

    logic [CW-1:0]          ch_reg;
    logic                   oor_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [31:0]     y1_reg, y2_reg, ycp_reg;
    logic signed [63:0]     prod_reg;
    logic signed [AW-1:0]   acc_reg;
    logic                   neg_reg;
    logic [QB-1:0]          num_reg;
    logic [32:0]            den_reg;
    logic [33:0]            rem_reg;
    logic [DC-1:0]          cnt_reg;
    logic                   full_reg;

    logic [IW-1:0] idx;
    assign idx = ch_reg[IW-1:0];

    logic signed [AW-1:0] ysum;
    logic signed [31:0] ysat;
    logic [31:0]        ymag;
    logic [33:0]        rtry;
    logic signed [32:0] yc_s;
    logic signed [33:0] diff;
    logic signed [64:0] ofl;
    logic signed [SAMPLE_BITS-1:0] osat;
    localparam int OSH = 57 - SAMPLE_BITS;

    assign ysum = acc_reg + AW'(prod_reg >>> 28);
    always_comb begin
        if (ysum > 38'sd2147483647)       ysat = 32'sh7fffffff;
        else if (ysum < -38'sd2147483648) ysat = 32'sh80000000;
        else                              ysat = ysum[31:0];
    end
    assign ymag = ysat[31] ? 32'(-ysat) : ysat;
    assign rtry = {rem_reg[32:0], num_reg[QB-1]} - {1'b0, den_reg};
    assign yc_s = neg_reg ? -$signed({1'b0, num_reg[31:0]}) : $signed({1'b0, num_reg[31:0]});
    assign diff = 34'(yc_s) - 34'(ycp_reg);
    assign ofl  = 65'(prod_reg >>> OSH);

    localparam logic signed [64:0] SMAX = 65'sd1 <<< (SAMPLE_BITS - 1);
    always_comb begin
        if (ofl >= SMAX)       osat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else if (ofl < -SMAX)  osat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else                   osat = ofl[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg  <= '0;
            full_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (out_take) full_reg <= 1'b0;
            if (cmd.outp) full_reg <= 1'b1;
            if (cmd.sum && !oor_reg) vld_reg[idx] <= 1'b1;
            if (cmd.sum) cnt_reg <= DC'(QB);
            else if (cmd.div_step) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            ch_reg  <= in_channel;
            x_reg   <= in_sample;
            oor_reg <= ({29'd0, in_channel} >= CHANNELS);
        end
        if (cmd.mul_a) begin
            y1_reg  <= vld_reg[idx] ? y1_mem[idx] : '0;
            y2_reg  <= vld_reg[idx] ? y2_mem[idx] : '0;
            ycp_reg <= vld_reg[idx] ? yc_mem[idx] : '0;
            prod_reg <= a1_reg * 64'(x_reg);
            acc_reg  <= '0;
        end
        if (cmd.mul_b1) begin
            acc_reg  <= AW'(prod_reg >>> (SAMPLE_BITS - 1));
            prod_reg <= b1_reg * 64'(y1_reg);
        end
        if (cmd.mul_b2) begin
            acc_reg  <= ysum;
            prod_reg <= b2_reg * 64'(y2_reg);
        end
        if (cmd.sum) begin
            neg_reg <= ysat[31];
            num_reg <= QB'(ymag) * QB'(c_reg);
            den_reg <= 33'(ymag) + 33'(c_reg);
            rem_reg <= '0;
            if (!oor_reg) begin
                y2_mem[idx] <= y1_reg;
                y1_mem[idx] <= ysat;
            end
        end
        if (cmd.div_step) begin
            // quotient bits shift into num_reg
            if (!rtry[33] && den_reg != '0) begin
                rem_reg <= rtry;
                num_reg <= {num_reg[QB-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[32:0], num_reg[QB-1]};
                num_reg <= {num_reg[QB-2:0], 1'b0};
            end
        end
        if (cmd.fin) begin
            prod_reg <= 64'(diff) * 64'($signed({1'b0, g_reg}));
            if (!oor_reg) yc_mem[idx] <= yc_s[31:0];
        end
        if (cmd.outp) begin
            out_channel <= ch_reg;
            out_sample  <= oor_reg ? '0 : osat;
        end
    end

    assign sts.div_done = (cnt_reg == '0);
    assign sts.out_full = full_reg;

    a_full_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.outp |=> full_reg) else $error("output not held");
    a_cnt_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum |=> cnt_reg == DC'(QB)) else $error("divider count");
    a_vld_kept: assert property (@(posedge clk) disable iff (!rst_n)
        $past(vld_reg[0]) |-> vld_reg[0]) else $error("valid lost");
endmodule

@@ rtl/lrs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_ctrl
// Sequencer: load, three multiplies, sum and state write, divide, output product, output.
// ----------------------------------------------------------------------------
module lrs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    output logic               in_ready,
    input  lrs_pkg::lrs_sts_t  sts,
    output lrs_pkg::lrs_cmd_t  cmd
);
    localparam logic [2:0] S_IDLE = 3'd0, S_MA = 3'd1, S_B1 = 3'd2, S_B2 = 3'd3,
                           S_SUM = 3'd4, S_DIV = 3'd5, S_FIN = 3'd6, S_OUT = 3'd7;
    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: if (in_fire) begin cmd.load = 1'b1; state_next = S_MA; end
            S_MA:   begin cmd.mul_a = 1'b1;  state_next = S_B1; end
            S_B1:   begin cmd.mul_b1 = 1'b1; state_next = S_B2; end
            S_B2:   begin cmd.mul_b2 = 1'b1; state_next = S_SUM; end
            S_SUM:  begin cmd.sum = 1'b1;    state_next = S_DIV; end
            S_DIV:
                if (sts.div_done) state_next = S_FIN;
                else cmd.div_step = 1'b1;
            S_FIN:  begin cmd.fin = 1'b1;    state_next = S_OUT; end
            S_OUT:
                if (!sts.out_full) begin cmd.outp = 1'b1; state_next = S_IDLE; end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_MA) else $error("load sequence");
    a_no_out_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.outp |-> !sts.out_full) else $error("overwrite of output");
endmodule

@@ rtl/loudspeaker_resonance_softclip_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loudspeaker_resonance_softclip_top
// Resonator, soft clipper and differentiating output stage per channel.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)              | tuser
// s_axis  | in  | sample_in                       | channel
// m_axis  | out | sample_out                      | channel_out
// cfg     | in  | cfg_we, cfg_idx, cfg_data       | -
// Each beat runs through the 62-step restoring divider.
// Next beat is taken once the previous result sits in the output register.
// Reset zeroes a1/b1/b2, presets clip scale and gain, clears all channel state (valid bits).
// A stalled output holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module loudspeaker_resonance_softclip_top #(
    parameter int CHANNELS    = lrs_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = lrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [lrs_pkg::CFG_IDX_BITS-1:0]           cfg_idx,
    input  logic [lrs_pkg::COEF_BITS-1:0]              cfg_data,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]           s_axis_tdata, // sample_in
    input  logic [lrs_pkg::CH_BITS-1:0]                s_axis_tuser, // channel
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]           m_axis_tdata, // sample_out
    output logic [lrs_pkg::CH_BITS-1:0]                m_axis_tuser  // channel_out
);
    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
    lrs_pkg::lrs_cmd_t cmd;
    lrs_pkg::lrs_sts_t sts;
    logic signed [SAMPLE_BITS-1:0] osample;
    logic in_fire, out_take;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_take = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = sts.out_full;
    assign m_axis_tdata  = DW'($unsigned(osample));

    lrs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_ready(s_axis_tready),
        .sts(sts), .cmd(cmd)
    );

    lrs_datapath #(.CHANNELS(CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .in_channel(s_axis_tuser),
        .in_sample(s_axis_tdata[SAMPLE_BITS-1:0]), .cmd(cmd), .sts(sts),
        .out_take(out_take), .out_channel(m_axis_tuser), .out_sample(osample)
    );
endmodule
